// ----- design/mvwo_pkg.sv -----
// Shared types and constants for the multi-voice wavetable oscillator.
`default_nettype none

package mvwo_pkg;

  // Field widths of the streams and the configuration port
  localparam int CMD_W      = 2;
  localparam int TARGET_W   = 8;
  localparam int SAMPLE_W   = 16;
  localparam int WORD_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int VIU_W      = 5;

  // Item command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TABLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PHASE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VOICES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

  // Register reset values
  localparam logic [VIU_W-1:0]             VOICES_RST = 5'd1;
  localparam logic signed [SAMPLE_W-1:0]   GAIN_RST   = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0]   OFFSET_RST = 16'sh0000;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_VOICE,
    ST_INDEX,
    ST_RD_T0,
    ST_RD_T1,
    ST_INTERP,
    ST_SCALE,
    ST_ACCUM,
    ST_DONE
  } state_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic item_write;
    logic tick_start;
    logic rd_voice;
    logic calc_index;
    logic rd_t0;
    logic rd_t1;
    logic interp;
    logic scale;
    logic accum;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic count_zero;
    logic last_voice;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- design/mvwo_ctrl.sv -----
// Sequencer that steps the datapath through one tick, voice by voice.
`default_nettype none

module mvwo_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    item_valid,
  output logic                         item_ready,
  input  wire logic [mvwo_pkg::CMD_W-1:0] item_cmd,
  input  wire mvwo_pkg::dp_stat_t      stat,
  output mvwo_pkg::dp_cmd_t            cmd
);
  import mvwo_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid && item_cmd == CMD_TICK) begin
          state_next = stat.count_zero ? ST_DONE : ST_RD_VOICE;
        end
      end
      ST_RD_VOICE: state_next = ST_INDEX;
      ST_INDEX:    state_next = ST_RD_T0;
      ST_RD_T0:    state_next = ST_RD_T1;
      ST_RD_T1:    state_next = ST_INTERP;
      ST_INTERP:   state_next = ST_SCALE;
      ST_SCALE:    state_next = ST_ACCUM;
      ST_ACCUM:    state_next = stat.last_voice ? ST_DONE : ST_RD_VOICE;
      ST_DONE: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready     = 1'b1;
        cmd.item_write = item_valid && item_cmd != CMD_TICK;
        cmd.tick_start = item_valid && item_cmd == CMD_TICK;
      end
      ST_RD_VOICE: cmd.rd_voice   = 1'b1;
      ST_INDEX:    cmd.calc_index = 1'b1;
      ST_RD_T0:    cmd.rd_t0      = 1'b1;
      ST_RD_T1:    cmd.rd_t1      = 1'b1;
      ST_INTERP:   cmd.interp     = 1'b1;
      ST_SCALE:    cmd.scale      = 1'b1;
      ST_ACCUM:    cmd.accum      = 1'b1;
      ST_DONE:     cmd.load_out   = stat.out_free;
      default:     cmd            = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/mvwo_datapath.sv -----
// Datapath: wave table, voice memories, interpolation, scaling, sum and output register.
`default_nettype none

module mvwo_datapath #(
  parameter int TABLE_DEPTH = 256,
  parameter int MAX_VOICES  = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire mvwo_pkg::dp_cmd_t                    cmd,
  output mvwo_pkg::dp_stat_t                        stat,
  input  wire logic [mvwo_pkg::CMD_W-1:0]           item_cmd,
  input  wire logic [mvwo_pkg::TARGET_W-1:0]        item_target,
  input  wire logic signed [mvwo_pkg::SAMPLE_W-1:0] item_sample,
  input  wire logic [mvwo_pkg::WORD_W-1:0]          item_word,
  input  wire logic                                 cfg_we,
  input  wire logic [mvwo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mvwo_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [mvwo_pkg::SAMPLE_W-1:0]      out_audio,
  output logic                                      out_clip
);
  import mvwo_pkg::*;

  localparam int TAB_AW   = $clog2(TABLE_DEPTH);
  localparam int DEPTH_W  = $clog2(TABLE_DEPTH + 1);
  localparam int P_W      = WORD_W + DEPTH_W;
  localparam int VOICE_AW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CNT_W    = $clog2(MAX_VOICES + 1);
  localparam int S_W      = 34;
  localparam int PROD_W   = S_W + SAMPLE_W;
  localparam int TERM_W   = PROD_W - 31;
  localparam int VAL_W    = TERM_W + 1;
  localparam int SUM_W    = VAL_W + CNT_W;

  localparam logic [P_W-1:0]             DEPTH_K    = P_W'(TABLE_DEPTH);
  localparam logic [TAB_AW-1:0]          LAST_IDX   = TAB_AW'(TABLE_DEPTH - 1);
  localparam logic signed [PROD_W-1:0]   ROUND_HALF = PROD_W'(1) << 30;
  localparam logic signed [SUM_W-1:0]    SAT_HI     = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0]    SAT_LO     = SUM_W'(-32768);

  // Configuration registers
  logic [VIU_W-1:0]           voices_in_use;
  logic signed [SAMPLE_W-1:0] gain;
  logic signed [SAMPLE_W-1:0] offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      voices_in_use <= VOICES_RST;
      gain          <= GAIN_RST;
      offset        <= OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VOICES: voices_in_use <= cfg_data[VIU_W-1:0];
        CFG_GAIN:   gain          <= cfg_data;
        CFG_OFFSET: offset        <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Clamp the voice count to the bank size
  logic [CNT_W-1:0] voice_count;
  always_comb begin
    if (32'(voices_in_use) > 32'(MAX_VOICES)) begin
      voice_count = CNT_W'(MAX_VOICES);
    end else begin
      voice_count = CNT_W'(voices_in_use);
    end
  end

  // Voice counter
  logic [CNT_W-1:0]    vcnt;
  logic [CNT_W-1:0]    vcnt_next;
  logic [VOICE_AW-1:0] vidx;

  assign vcnt_next = vcnt + 1'b1;
  assign vidx      = vcnt[VOICE_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vcnt <= '0;
    end else if (cmd.tick_start) begin
      vcnt <= '0;
    end else if (cmd.accum) begin
      vcnt <= vcnt_next;
    end
  end

  // Decode item writes
  logic                tab_target_ok;
  logic                voice_target_ok;
  logic [VOICE_AW-1:0] voice_wa;
  logic                tab_we;
  logic                step_we;

  assign tab_target_ok   = 32'(item_target) < 32'(TABLE_DEPTH);
  assign voice_target_ok = 32'(item_target) < 32'(MAX_VOICES);
  assign voice_wa        = VOICE_AW'(item_target);
  assign tab_we  = cmd.item_write && item_cmd == CMD_TABLE && tab_target_ok;
  assign step_we = cmd.item_write && item_cmd == CMD_STEP && voice_target_ok;

  // Voice memories with valid bits; an entry not yet written reads as zero
  logic [WORD_W-1:0]     phase_mem [MAX_VOICES];
  logic [WORD_W-1:0]     step_mem  [MAX_VOICES];
  logic [MAX_VOICES-1:0] phase_ok;
  logic [MAX_VOICES-1:0] step_ok;
  logic [WORD_W-1:0]     phase_rd;
  logic [WORD_W-1:0]     step_rd;
  logic                  phase_rv;
  logic                  step_rv;
  logic [WORD_W-1:0]     phase_eff;
  logic [WORD_W-1:0]     step_eff;
  logic                  phase_we;
  logic [VOICE_AW-1:0]   phase_wa;
  logic [WORD_W-1:0]     phase_wd;

  assign phase_eff = phase_rv ? phase_rd : '0;
  assign step_eff  = step_rv ? step_rd : '0;

  // Pick the phase write source: an item write or the tick write-back
  always_comb begin
    phase_we = 1'b0;
    phase_wa = vidx;
    phase_wd = phase_eff + step_eff;
    if (cmd.item_write && item_cmd == CMD_PHASE && voice_target_ok) begin
      phase_we = 1'b1;
      phase_wa = voice_wa;
      phase_wd = item_word;
    end else if (cmd.accum) begin
      phase_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (phase_we) begin
      phase_mem[phase_wa] <= phase_wd;
    end
    if (step_we) begin
      step_mem[voice_wa] <= item_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ok <= '0;
      step_ok  <= '0;
    end else begin
      if (phase_we) begin
        phase_ok[phase_wa] <= 1'b1;
      end
      if (step_we) begin
        step_ok[voice_wa] <= 1'b1;
      end
    end
  end

  // Read the voice's phase and increment
  always_ff @(posedge clk) begin
    if (cmd.rd_voice) begin
      phase_rd <= phase_mem[vidx];
      step_rd  <= step_mem[vidx];
      phase_rv <= phase_ok[vidx];
      step_rv  <= step_ok[vidx];
    end
  end

  // Split the scaled phase into table index and weight
  logic [P_W-1:0]    p_full;
  logic [TAB_AW-1:0] idx0;
  logic [TAB_AW-1:0] idx1;
  logic [15:0]       frac;

  assign p_full = P_W'(phase_eff) * DEPTH_K;
  assign idx1   = (idx0 == LAST_IDX) ? '0 : idx0 + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.calc_index) begin
      idx0 <= p_full[WORD_W +: TAB_AW];
      frac <= p_full[31:16];
    end
  end

  // Wave table: one write port, one registered read port
  logic signed [SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];
  logic signed [SAMPLE_W-1:0] tab_rd;
  logic [TAB_AW-1:0]          tab_ra;
  logic [TAB_AW-1:0]          tab_wa;

  assign tab_ra = cmd.rd_t1 ? idx1 : idx0;
  assign tab_wa = TAB_AW'(item_target);

  always_ff @(posedge clk) begin
    if (tab_we) begin
      wave_mem[tab_wa] <= item_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_t0 || cmd.rd_t1) begin
      tab_rd <= wave_mem[tab_ra];
    end
  end

  // Interpolate: lower entry weighted first, upper entry added next
  logic [16:0]              wlow;
  logic signed [17:0]       wlow_s;
  logic signed [16:0]       frac_s;
  logic signed [S_W-1:0]    prod0;
  logic signed [S_W-1:0]    interp_val;
  logic signed [PROD_W-1:0] scaled;

  assign wlow   = 17'h10000 - {1'b0, frac};
  assign wlow_s = {1'b0, wlow};
  assign frac_s = {1'b0, frac};

  always_ff @(posedge clk) begin
    if (cmd.rd_t1) begin
      prod0 <= wlow_s * tab_rd;
    end
    if (cmd.interp) begin
      interp_val <= prod0 + frac_s * tab_rd;
    end
    if (cmd.scale) begin
      scaled <= interp_val * gain;
    end
  end

  // Round to Q1.15, add offset and accumulate
  logic signed [PROD_W-1:0] rounded;
  logic signed [TERM_W-1:0] term;
  logic signed [VAL_W-1:0]  voice_val;
  logic signed [SUM_W-1:0]  sum;

  assign rounded   = scaled + ROUND_HALF;
  assign term      = rounded[PROD_W-1:31];
  assign voice_val = {term[TERM_W-1], term} + {{(VAL_W-SAMPLE_W){offset[SAMPLE_W-1]}}, offset};

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      sum <= '0;
    end else if (cmd.accum) begin
      sum <= sum + {{(SUM_W-VAL_W){voice_val[VAL_W-1]}}, voice_val};
    end
  end

  // Saturate the sum
  logic signed [SAMPLE_W-1:0] sat_val;
  logic                       sat_clip;

  always_comb begin
    if (sum > SAT_HI) begin
      sat_val  = 16'sh7FFF;
      sat_clip = 1'b1;
    end else if (sum < SAT_LO) begin
      sat_val  = 16'sh8000;
      sat_clip = 1'b1;
    end else begin
      sat_val  = sum[SAMPLE_W-1:0];
      sat_clip = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_audio <= sat_val;
      out_clip  <= sat_clip;
    end
  end

  // Status back to the sequencer
  assign stat.count_zero = voice_count == '0;
  assign stat.last_voice = vcnt_next == voice_count;
  assign stat.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- design/multi_voice_wavetable_oscillator_top.sv -----
// Top level of the multi-voice wavetable oscillator.
//
//   port group  direction  carries
//   s_*         in         one command item: table write, voice write or tick
//   m_*         out        one audio sample per tick
//   cfg_*       in         register writes: voice count, gain, offset
//
// Table, increment and phase writes are done in the cycle they are taken; the next item is
// taken in the following cycle.
// A tick steps through the voices in use one at a time: each voice passes
// through the single table read port, which reads the two neighbours in turn,
// and a shared interpolation and gain path. A tick with no voice goes from
// idle straight to the output stage.
// Items wait while a tick runs; a tick also stalls at the end of its sum
// while the previous sample still sits unread in the output register.
// Reset clears registers, voice phases and increments at once; the wave
// table is not cleared.
`default_nettype none

module multi_voice_wavetable_oscillator_top #(
  parameter int TABLE_DEPTH = 256,
  parameter int MAX_VOICES  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // target[7:0], sample_value[23:8], word_value[55:24]
  input  wire logic [1:0]  s_tuser,   // cmd[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // audio_out[15:0]
  output logic [0:0]       m_tuser,   // clipped[0]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import mvwo_pkg::*;

  dp_cmd_t                    dp_cmd;
  dp_stat_t                   dp_stat;
  logic signed [SAMPLE_W-1:0] out_audio;
  logic                       out_clip;

  // Sequencer
  mvwo_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s_tvalid),
    .item_ready (s_tready),
    .item_cmd   (s_tuser),
    .stat       (dp_stat),
    .cmd        (dp_cmd)
  );

  // Datapath
  mvwo_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_VOICES  (MAX_VOICES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (dp_cmd),
    .stat        (dp_stat),
    .item_cmd    (s_tuser),
    .item_target (s_tdata[7:0]),
    .item_sample (s_tdata[23:8]),
    .item_word   (s_tdata[55:24]),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_audio   (out_audio),
    .out_clip    (out_clip)
  );

  assign m_tdata    = out_audio;
  assign m_tuser[0] = out_clip;

endmodule

`default_nettype wire

// ----- test/mvwo_checker.sv -----
// Checker for the wavetable oscillator: tracks the voice state, predicts each sample, compares.
module mvwo_checker #(
  parameter int TABLE_DEPTH = 256,
  parameter int MAX_VOICES  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,   // target[7:0], sample_value[23:8], word_value[55:24]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // audio_out[15:0]
  input  logic [0:0]  m_tuser,   // clipped[0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          failures,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mvwo_pkg::*;

  typedef struct packed {
    logic signed [15:0] audio;
    logic               clip;
  } audio_t;

  // Shadow copy of the oscillator state
  logic signed [15:0] wave_tbl [TABLE_DEPTH];
  logic [31:0]        phase_acc [MAX_VOICES];
  logic [31:0]        phase_inc [MAX_VOICES];
  logic [VIU_W-1:0]   n_voices;
  logic signed [15:0] amp;
  logic signed [15:0] bias;
  audio_t             sample_q [$];
  int                 fail_count;

  // Sum the interpolated voices, advance the phases, then saturate the sum
  function automatic audio_t mix_voices();
    audio_t          r;
    int              count;
    int              k;
    int              i0;
    int              i1;
    longint unsigned p;
    longint          frac;
    longint          wsum;
    longint          term;
    longint          sum;
    sum = 0;
    count = (n_voices > MAX_VOICES) ? MAX_VOICES : int'(n_voices);
    for (k = 0; k < count; k++) begin
      p = longint'(phase_acc[k]) * TABLE_DEPTH;
      i0 = int'(p >> 32);
      if (i0 >= TABLE_DEPTH) i0 = TABLE_DEPTH - 1;
      i1 = (i0 + 1 >= TABLE_DEPTH) ? 0 : i0 + 1;
      frac = longint'((p >> 16) & 64'hFFFF);
      wsum = (65536 - frac) * longint'(wave_tbl[i0]) + frac * longint'(wave_tbl[i1]);
      // round to Q15 with halves up; arithmetic shift floors
      term = (wsum * longint'(amp) + (longint'(1) << 30)) >>> 31;
      sum += term + longint'(bias);
    end
    for (k = 0; k < count; k++) phase_acc[k] = phase_acc[k] + phase_inc[k];
    if (sum > 32767) begin
      r.audio = 16'sh7FFF;
      r.clip  = 1'b1;
    end else if (sum < -32768) begin
      r.audio = 16'sh8000;
      r.clip  = 1'b1;
    end else begin
      r.audio = 16'(sum);
      r.clip  = 1'b0;
    end
    return r;
  endfunction

  initial begin
    fail_count = 0;
    failures   = 0;
    pending    = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) wave_tbl[i] = '0;
  end

  always @(posedge clk) begin
    audio_t exp_smp;
    if (rst) begin
      for (int v = 0; v < MAX_VOICES; v++) begin
        phase_acc[v] = '0;
        phase_inc[v] = '0;
      end
      n_voices = VOICES_RST;
      amp      = GAIN_RST;
      bias     = OFFSET_RST;
      sample_q.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_VOICES: n_voices = cfg_data[VIU_W-1:0];
          CFG_GAIN:   amp      = cfg_data;
          CFG_OFFSET: bias     = cfg_data;
          default: ;
        endcase
      end
      // Apply each accepted item to the shadow state
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          CMD_TABLE: begin
            if (s_tdata[7:0] < TABLE_DEPTH) wave_tbl[s_tdata[7:0]] = s_tdata[23:8];
          end
          CMD_STEP: begin
            if (s_tdata[7:0] < MAX_VOICES) phase_inc[s_tdata[7:0]] = s_tdata[55:24];
          end
          CMD_PHASE: begin
            if (s_tdata[7:0] < MAX_VOICES) phase_acc[s_tdata[7:0]] = s_tdata[55:24];
          end
          default: sample_q.push_back(mix_voices());
        endcase
      end
      // Compare each delivered sample with the oldest prediction
      if (m_tvalid && m_tready) begin
        if (sample_q.size() == 0) begin
          $error("unexpected sample: audio_out %0d clipped %0d", $signed(m_tdata), m_tuser);
          fail_count++;
        end else begin
          exp_smp = sample_q.pop_front();
          if (m_tdata !== exp_smp.audio) begin
            $error("audio_out mismatch: expected %0d, got %0d",
                   exp_smp.audio, $signed(m_tdata));
            fail_count++;
          end
          if (m_tuser[0] !== exp_smp.clip) begin
            $error("clipped mismatch: expected %0d, got %0d", exp_smp.clip, m_tuser[0]);
            fail_count++;
          end
        end
      end
    end
    failures = fail_count;
    pending  = sample_q.size();
  end

endmodule

// ----- test/testbench.sv -----
// Stimulus and verdict for the multi-voice wavetable oscillator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mvwo_pkg::*;

  localparam int TABLE_DEPTH  = 256;
  localparam int MAX_VOICES   = 16;
  localparam int RANDOM_ITEMS = 850;
  localparam int N_ROUNDS     = 8;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = 130;   // longer than the slowest tick
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;   // target[7:0], sample_value[23:8], word_value[55:24]
  logic [1:0]  s_tuser;   // cmd[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // audio_out[15:0]
  logic [0:0]  m_tuser;   // clipped[0]
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int failures;
  int pending;
  bit calm;       // no idling on either side while set
  bit hold_req;   // ask the receiver for one long hold-off

  multi_voice_wavetable_oscillator_top #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_VOICES (MAX_VOICES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  mvwo_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_VOICES (MAX_VOICES)
  ) CHK (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #(10_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_q15();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFF00_0000 | 32'($urandom_range(0, 32'h00FF_FFFF));
      3:       return 32'($urandom_range(0, 32'h00FF_FFFF));
      default: return $urandom;
    endcase
  endfunction

  // Offer one item and hold it until it is taken
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] tgt,
                           input logic [15:0] smp, input logic [31:0] word);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tuser  <= cmd;
    s_tdata  <= {word, smp, tgt};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Write every register; the unused index gets junk that must change nothing
  task automatic set_config(input int voices, input logic [15:0] g, input logic [15:0] o);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(CFG_VOICES, (16'($urandom) & ~16'h001F) | 16'(voices & 5'h1F));
    write_reg(CFG_GAIN, g);
    write_reg(CFG_OFFSET, o);
    write_reg(CFG_UNUSED, junk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering until every sample is back and the block has gone quiet
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_item();
    int r;
    logic [7:0] tgt;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_item(CMD_TICK, 8'($urandom), 16'($urandom), $urandom);
    end else if (r < 65) begin
      send_item(CMD_TABLE, 8'($urandom), pick_q15(), $urandom);
    end else begin
      if ($urandom_range(0, 9) == 0) tgt = 8'($urandom_range(MAX_VOICES, 255));
      else tgt = 8'($urandom_range(0, MAX_VOICES - 1));
      send_item((r < 82) ? CMD_STEP : CMD_PHASE, tgt, 16'($urandom), pick_word());
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        int len;
        len = idle_len();
        if (len > 0) begin
          m_tready <= 1'b0;
          repeat (len) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Stimulus
  initial begin
    int voice_set [N_ROUNDS] = '{1, 16, 0, 4, 31, 2, 17, 8};
    int per_phase;
    logic [15:0] g;
    logic [15:0] o;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_TICK;
    cfg_we    = 1'b0;
    cfg_index = CFG_VOICES;
    cfg_data  = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Load the whole table so no tick reads an unwritten entry;
    // full-scale values sit on both sides of the wrap point
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      case (i)
        0:                 send_item(CMD_TABLE, 8'(i), 16'h8000, $urandom);
        1:                 send_item(CMD_TABLE, 8'(i), 16'h7FFF, $urandom);
        TABLE_DEPTH - 1:   send_item(CMD_TABLE, 8'(i), 16'h7FFF, $urandom);
        default:           send_item(CMD_TABLE, 8'(i), 16'($urandom), $urandom);
      endcase
    end

    // Directed: reset settings, wrap at table end, ignored voice numbers
    send_item(CMD_TICK, 8'h00, 16'h0000, 32'h0);
    send_item(CMD_PHASE, 8'd0, 16'h0000, 32'hFFFF_FFFF);
    send_item(CMD_STEP, 8'd0, 16'h0000, 32'h0000_0100);
    send_item(CMD_TICK, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_TICK, 8'h00, 16'h0000, 32'h0);
    send_item(CMD_PHASE, 8'd0, 16'h0000, 32'hFF80_0000);
    send_item(CMD_TICK, 8'h00, 16'h0000, 32'h0);
    send_item(CMD_STEP, 8'd0, 16'h0000, 32'hFFFF_FFFF);
    send_item(CMD_TICK, 8'h00, 16'h0000, 32'h0);
    send_item(CMD_TICK, 8'h00, 16'h0000, 32'h0);
    send_item(CMD_PHASE, 8'(MAX_VOICES - 1), 16'h0000, 32'h1234_5678);
    send_item(CMD_PHASE, 8'(MAX_VOICES), 16'h0000, 32'hDEAD_BEEF);
    send_item(CMD_STEP, 8'hFF, 16'h0000, 32'h0BAD_F00D);

    // Directed: no voice, too many voices, clipping both ways
    drain();
    set_config(0, 16'h7FFF, 16'h7FFF);
    send_item(CMD_TICK, 8'h00, 16'h0000, 32'h0);
    drain();
    set_config(31, 16'h8000, 16'h7FFF);
    send_item(CMD_TICK, 8'h00, 16'h0000, 32'h0);
    send_item(CMD_TICK, 8'h00, 16'h0000, 32'h0);
    drain();
    set_config(16, 16'h7FFF, 16'h8000);
    send_item(CMD_TICK, 8'h00, 16'h0000, 32'h0);
    drain();
    set_config(3, 16'h8000, 16'h8000);
    send_item(CMD_TICK, 8'h00, 16'h0000, 32'h0);

    // Back-pressure: the receiver holds off while ticks keep coming
    drain();
    set_config(2, 16'h4000, 16'h0000);
    calm     = 1'b1;
    hold_req = 1'b1;
    repeat (30) send_item(CMD_TICK, 8'($urandom), 16'($urandom), $urandom);
    calm = 1'b0;

    // Random phases, each with its own register setting
    per_phase = RANDOM_ITEMS / N_ROUNDS;
    for (int ph = 0; ph < N_ROUNDS; ph++) begin
      drain();
      case (ph)
        1:       g = 16'h8000;
        3:       g = 16'h7FFF;
        4:       g = 16'h0000;
        default: g = 16'($urandom);
      endcase
      case (ph)
        5:       o = 16'h8000;
        6:       o = 16'h7FFF;
        default: o = 16'($urandom_range(0, 2000) - 1000);
      endcase
      set_config(voice_set[ph], g, o);
      calm = ($urandom_range(0, 3) == 0);
      repeat (per_phase) random_item();
      calm = 1'b0;
    end

    drain();
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
